// ===== rtl/bpq_pkg.sv =====
// Shared types and constants for the bounded priority queue.
package bpq_pkg;

	localparam int CAPACITY      = 16;
	localparam int PRIORITY_BITS = 16;
	localparam int VALUE_BITS    = 64;
	localparam int CNT_W         = $clog2(CAPACITY + 1);
	localparam int FILL_W        = 5;

	typedef logic [VALUE_BITS-1:0]           val_t;
	typedef logic signed [PRIORITY_BITS-1:0] pri_t;
	typedef logic [CNT_W-1:0]                cnt_t;

	// request codes
	localparam logic [1:0] ACT_PUSH = 2'd0;
	localparam logic [1:0] ACT_POP  = 2'd1;
	localparam logic [1:0] ACT_TOP  = 2'd2;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic push;
		logic pop;
	} bpq_ctl_t;

endpackage

// ===== rtl/bounded_priority_queue.sv =====
// Top level of the bounded priority queue: request channel, cell chain, result register.
// Usage:
//   Requests arrive on in_valid/in_ready with action, in_value and in_priority.
//   action push stores an entry, pop removes and returns the head, top returns
//   the head and leaves it in place. Entries leave highest priority first;
//   equal priorities leave in arrival order.
//   Each request gives one result on out_valid/out_ready: out_value (head
//   payload for pop/top, else zero), empty_error, full_drop, fill_count and
//   is_empty, the last two describing the store after the request.
// Result and throughput:
//   The result is registered in the cycle after the request is taken. A row of
//   CAPACITY cells compares the new priority in every slot at once and shifts
//   in parallel, so one request per cycle is sustained while out_ready is high.
// Reset:
//   arst_n clears the fill count and the result valid flag; the store is empty.
// Stall:
//   While a result waits and out_ready is low, in_ready is low; a result taken
//   in the same cycle frees the register for the next request.
module bounded_priority_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  action,
	input  logic [63:0]                 in_value,
	input  logic signed [15:0]          in_priority,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [63:0]                 out_value,
	output logic                        empty_error,
	output logic                        full_drop,
	output logic [bpq_pkg::FILL_W-1:0]  fill_count,
	output logic                        is_empty
);
	import bpq_pkg::*;

	cnt_t     count_q;
	logic     out_valid_q;
	val_t     out_value_q;
	logic     empty_error_q;
	logic     full_drop_q;
	cnt_t     count_res_q;

	logic     accept;
	logic     is_push, is_pop, is_top;
	logic     full, none;
	bpq_ctl_t ctl;
	cnt_t     count_nxt;
	pri_t     new_pri;

	val_t     cell_value [CAPACITY];
	pri_t     cell_pri   [CAPACITY];
	logic     ins        [CAPACITY+1];

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign new_pri  = pri_t'(in_priority[PRIORITY_BITS-1:0]);
	assign full     = (count_q == cnt_t'(CAPACITY));
	assign none     = (count_q == '0);

	// request decode
	always_comb begin
		is_push = 1'b0;
		is_pop  = 1'b0;
		is_top  = 1'b0;
		unique case (action)
			ACT_PUSH: is_push = 1'b1;
			ACT_POP:  is_pop  = 1'b1;
			ACT_TOP:  is_top  = 1'b1;
			default:  ;
		endcase
	end

	// chain command and next fill count
	always_comb begin
		ctl.push  = accept && is_push && !full;
		ctl.pop   = accept && is_pop && !none;
		count_nxt = count_q;
		if (ctl.push)
			count_nxt = count_q + cnt_t'(1);
		else if (ctl.pop)
			count_nxt = count_q - cnt_t'(1);
	end

	// cell chain
	assign ins[0] = 1'b0;
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		val_t right_value;
		pri_t right_pri;
		val_t left_value;
		pri_t left_pri;
		logic occ;

		assign occ = (cnt_t'(i) < count_q);

		if (i == 0) begin : g_first
			assign left_value = in_value;
			assign left_pri   = new_pri;
		end else begin : g_mid
			assign left_value = cell_value[i-1];
			assign left_pri   = cell_pri[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_value = cell_value[i];
			assign right_pri   = cell_pri[i];
		end else begin : g_inner
			assign right_value = cell_value[i+1];
			assign right_pri   = cell_pri[i+1];
		end

		bpq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occ         (occ),
			.new_value   (in_value),
			.new_pri     (new_pri),
			.ins_in      (ins[i]),
			.left_value  (left_value),
			.left_pri    (left_pri),
			.right_value (right_value),
			.right_pri   (right_pri),
			.value       (cell_value[i]),
			.pri         (cell_pri[i]),
			.ins_out     (ins[i+1])
		);
	end

	// fill count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			out_value_q   <= ((is_pop || is_top) && !none) ? cell_value[0] : '0;
			empty_error_q <= (is_pop || is_top) && none;
			full_drop_q   <= is_push && full;
			count_res_q   <= count_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_value   = out_value_q;
	assign empty_error = empty_error_q;
	assign full_drop   = full_drop_q;
	assign fill_count  = FILL_W'(count_res_q);
	assign is_empty    = (count_res_q == '0);

endmodule

// ===== rtl/bpq_cell.sv =====
// One slot of the sorted chain: holds an entry, shifts right on insert, left on pop.
module bpq_cell (
	input  logic             clk,
	input  bpq_pkg::bpq_ctl_t ctl,
	input  logic             occ,
	input  bpq_pkg::val_t    new_value,
	input  bpq_pkg::pri_t    new_pri,
	input  logic             ins_in,
	input  bpq_pkg::val_t    left_value,
	input  bpq_pkg::pri_t    left_pri,
	input  bpq_pkg::val_t    right_value,
	input  bpq_pkg::pri_t    right_pri,
	output bpq_pkg::val_t    value,
	output bpq_pkg::pri_t    pri,
	output logic             ins_out
);
	import bpq_pkg::*;

	val_t value_q;
	pri_t pri_q;

	// new item belongs here or further left when this slot is free or ranks lower
	assign ins_out = !(occ && (pri_q >= new_pri));

	// slot update: take new item at the insert point, left neighbor behind it,
	// right neighbor on pop
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			if (ins_in) begin
				value_q <= left_value;
				pri_q   <= left_pri;
			end else if (ins_out) begin
				value_q <= new_value;
				pri_q   <= new_pri;
			end
		end else if (ctl.pop) begin
			value_q <= right_value;
			pri_q   <= right_pri;
		end
	end

	assign value = value_q;
	assign pri   = pri_q;

endmodule
